// ===== hdl/wildcard_byte_pattern_scanner_core_defines.svh =====
// assertion macros shared by the scanner rtl
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_CORE_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_CORE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define WBPS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scanner check failed");

// implication checked on the following edge
`define WBPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scanner check failed");

`endif

// ===== hdl/wbps_pkg.sv =====
// shared types and constants of the wildcard byte pattern scanner
package wbps_pkg;

  localparam int MAX_PATTERN_DEFAULT = 16;
  localparam int PAT_BYTES           = 16;
  localparam int CFG_DATA_W          = 64;
  localparam int CFG_INDEX_W         = 3;
  localparam int LEN_W               = 5;
  localparam int ADDR_W              = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WILDCARD     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SIZE  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_START   = 3'd5;

  localparam logic [LEN_W-1:0]  LENGTH_RESET      = 5'd1;
  localparam logic [ADDR_W-1:0] HEADER_SIZE_RESET = 32'd1024;
  localparam logic [ADDR_W-1:0] CODE_START_RESET  = 32'd4096;

  // pattern as seen by every cell, length already clamped
  typedef struct packed {
    logic [8*PAT_BYTES-1:0] bytes;
    logic [PAT_BYTES-1:0]   wild;
    logic [LEN_W-1:0]       len;
  } pat_cfg_t;

endpackage

// ===== hdl/wbps_cell.sv =====
// one history cell: holds a past byte and checks it against its pattern position
module wbps_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  logic              clear,
  input  logic [7:0]        byte_in,
  input  logic              valid_in,
  input  wbps_pkg::pat_cfg_t pat,
  output logic [7:0]        byte_out,
  output logic              valid_out,
  output logic              hit
);
  import wbps_pkg::*;

  localparam logic [LEN_W:0] NEED_LEN = (LEN_W + 1)'(IDX + 2);

  logic [7:0]       hist;
  logic             valid;
  logic             in_use;
  logic [LEN_W-1:0] sel_full;
  logic [3:0]       sel;
  logic [7:0]       pat_byte;

  always_ff @(posedge clk) begin
    if (rst || (shift && clear)) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      hist <= byte_in;
    end
  end

  // this cell holds the byte at pattern position len-2-IDX
  always_comb begin
    in_use   = {1'b0, pat.len} >= NEED_LEN;
    sel_full = pat.len - LEN_W'(IDX) - LEN_W'(2);
    sel      = sel_full[3:0];
    pat_byte = pat.bytes[8*sel +: 8];
    hit      = !in_use || (valid && (pat.wild[sel] || hist == pat_byte));
  end

  assign byte_out  = hist;
  assign valid_out = valid;

endmodule

// ===== hdl/wildcard_byte_pattern_scanner_core.sv =====
// Wildcard byte pattern scanner: takes one byte per beat and reports every occurrence
// of a pattern of up to MAX_PATTERN bytes (each exact or wildcard), overlaps included,
// on the beat of the byte that completes it. Past bytes sit in a row of MAX_PATTERN-1
// shift cells that all compare in parallel, so a new byte is taken every cycle unless
// the output stalls, and a result leaves through the output register in the cycle
// after its byte. A beat with tlast always yields a result with tlast set and clears
// the history and byte counter. The reported address is match start offset -
// header_size + code_start, modulo 2^32. The user must write registers through the
// cfg port only while no beat is in flight; the block does not enforce this.
`include "wildcard_byte_pattern_scanner_core_defines.svh"

module wildcard_byte_pattern_scanner_core #(
  parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,   // [7:0] data_byte
  input  logic                                s_tlast,   // last_byte
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [39:0]                         m_tdata,   // [0] found, [32:1] match_address
  output logic                                m_tlast,   // scan_done
  input  logic                                cfg_we,
  input  logic [wbps_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import wbps_pkg::*;

  localparam int HIST_CELLS = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

  logic [63:0]       pattern_low;
  logic [63:0]       pattern_high;
  logic [15:0]       wildcard_mask;
  logic [LEN_W-1:0]  pattern_length;
  logic [ADDR_W-1:0] header_size;
  logic [ADDR_W-1:0] code_start;

  logic [ADDR_W-1:0] byte_position;
  pat_cfg_t          pat;
  logic [LEN_W-1:0]  len_used;
  logic [LEN_W-1:0]  len_m1;
  logic              accept;
  logic              cur_ok;
  logic              found;
  logic [ADDR_W-1:0] start_offset;
  logic [ADDR_W-1:0] match_addr;

  logic [HIST_CELLS-1:0] cell_valid;
  logic [HIST_CELLS-1:0] cell_hit;
  logic [7:0]            cell_byte [HIST_CELLS];

  logic              out_found;
  logic [ADDR_W-1:0] out_addr;
  logic              out_done;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      wildcard_mask  <= '0;
      pattern_length <= LENGTH_RESET;
      header_size    <= HEADER_SIZE_RESET;
      code_start     <= CODE_START_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:  pattern_low    <= cfg_data;
        REG_PATTERN_HIGH: pattern_high   <= cfg_data;
        REG_WILDCARD:     wildcard_mask  <= cfg_data[15:0];
        REG_LENGTH:       pattern_length <= cfg_data[LEN_W-1:0];
        REG_HEADER_SIZE:  header_size    <= cfg_data[ADDR_W-1:0];
        REG_CODE_START:   code_start     <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // length clamped to 1..MAX_PATTERN
  always_comb begin
    if (pattern_length == '0) begin
      len_used = LEN_W'(1);
    end else if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      len_used = LEN_W'(MAX_PATTERN);
    end else begin
      len_used = pattern_length;
    end
    len_m1    = len_used - LEN_W'(1);
    pat.bytes = {pattern_high, pattern_low};
    pat.wild  = wildcard_mask;
    pat.len   = len_used;
  end

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // history chain, cell 0 takes the incoming byte
  for (genvar g = 0; g < HIST_CELLS; g++) begin : g_cell
    wbps_cell #(
      .IDX(g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (accept),
      .clear    (s_tlast),
      .byte_in  ((g == 0) ? s_tdata : cell_byte[(g == 0) ? 0 : g - 1]),
      .valid_in ((g == 0) ? 1'b1 : cell_valid[(g == 0) ? 0 : g - 1]),
      .pat      (pat),
      .byte_out (cell_byte[g]),
      .valid_out(cell_valid[g]),
      .hit      (cell_hit[g])
    );
  end

  always_comb begin
    cur_ok       = pat.wild[len_m1[3:0]] || s_tdata == pat.bytes[8*len_m1[3:0] +: 8];
    found        = cur_ok && (&cell_hit);
    start_offset = byte_position - ADDR_W'(len_m1);
    match_addr   = start_offset - header_size + code_start;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && s_tlast)) begin
      byte_position <= '0;
    end else if (accept) begin
      byte_position <= byte_position + ADDR_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= found || s_tlast;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_found <= found;
      out_addr  <= found ? match_addr : '0;
      out_done  <= s_tlast;
    end
  end

  assign m_tdata = {7'b0, out_addr, out_found};
  assign m_tlast = out_done;

  `WBPS_ASSERT_NOW(a_no_addr_without_match, clk, rst, m_tvalid && !out_found, out_addr == '0)
  `WBPS_ASSERT_NOW(a_stall_blocks_input, clk, rst, m_tvalid && !m_tready, !s_tready)
  `WBPS_ASSERT_NEXT(a_last_clears_scan, clk, rst, accept && s_tlast,
                    byte_position == '0 && cell_valid == '0)
  `WBPS_ASSERT_NEXT(a_position_steps, clk, rst, accept && !s_tlast,
                    byte_position == $past(byte_position) + ADDR_W'(1))

endmodule
